FILE: rtl/core/qpr_pkg.sv
// qpr_pkg: payload structs, controller command struct, multiply micro-op table
// and cordic arctangent table for the quaternion point rotator
// depends on nothing
`default_nettype none
package qpr_pkg;

   typedef struct packed {
      logic               action;
      logic signed [15:0] angle;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } qpr_req_type;

   typedef struct packed {
      logic signed [31:0] look_x;
      logic signed [31:0] look_y;
      logic signed [31:0] look_z;
      logic               saturated;
   } qpr_rsp_type;

   localparam int unsigned CNT_W    = 6;
   localparam int unsigned IDX_W    = 5;
   localparam int unsigned NUM_UOPS = 27;
   localparam int unsigned CRD_W    = 34;
   localparam int unsigned OPA_W    = 36;
   localparam int unsigned OPB_W    = 32;
   localparam int unsigned PROD_W   = OPA_W + OPB_W;
   localparam int unsigned ACC_W    = 40;
   localparam logic signed [CRD_W-1:0] GAIN_INV = 34'sd652032874;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_ROTATE = 1'b1;

   typedef enum logic [3:0] {
      A_AX, A_AY, A_AZ, A_PX, A_PY, A_PZ, A_TX, A_TY, A_TZ, A_TW
   } a_sel_type;

   typedef enum logic [2:0] {
      B_CY, B_QW, B_QX, B_QY, B_QZ
   } b_sel_type;

   typedef enum logic [3:0] {
      D_QX, D_QY, D_QZ, D_TX, D_TY, D_TZ, D_TW, D_RX, D_RY, D_RZ
   } dest_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      sh17;
      logic      neg;
      logic      first;
      logic      last;
      dest_type  dest;
   } uop_type;

   typedef struct packed {
      logic             load_point;
      logic             cordic_init;
      logic             cordic_step;
      logic [IDX_W-1:0] cordic_idx;
      logic             uop_valid;
      logic [IDX_W-1:0] uop_idx;
      logic             out_load;
   } qpr_cmd_type;

   function automatic uop_type uop_rom(input logic [IDX_W-1:0] idx);
      uop_type u;
      case (idx)
         5'd0:  u = '{A_AX, B_CY, 1'b1, 1'b0, 1'b1, 1'b1, D_QX};
         5'd1:  u = '{A_AY, B_CY, 1'b1, 1'b0, 1'b1, 1'b1, D_QY};
         5'd2:  u = '{A_AZ, B_CY, 1'b1, 1'b0, 1'b1, 1'b1, D_QZ};
         5'd3:  u = '{A_PX, B_QW, 1'b0, 1'b0, 1'b1, 1'b0, D_TX};
         5'd4:  u = '{A_PZ, B_QY, 1'b0, 1'b0, 1'b0, 1'b0, D_TX};
         5'd5:  u = '{A_PY, B_QZ, 1'b0, 1'b1, 1'b0, 1'b1, D_TX};
         5'd6:  u = '{A_PY, B_QW, 1'b0, 1'b0, 1'b1, 1'b0, D_TY};
         5'd7:  u = '{A_PZ, B_QX, 1'b0, 1'b1, 1'b0, 1'b0, D_TY};
         5'd8:  u = '{A_PX, B_QZ, 1'b0, 1'b0, 1'b0, 1'b1, D_TY};
         5'd9:  u = '{A_PZ, B_QW, 1'b0, 1'b0, 1'b1, 1'b0, D_TZ};
         5'd10: u = '{A_PY, B_QX, 1'b0, 1'b0, 1'b0, 1'b0, D_TZ};
         5'd11: u = '{A_PX, B_QY, 1'b0, 1'b1, 1'b0, 1'b1, D_TZ};
         5'd12: u = '{A_PX, B_QX, 1'b0, 1'b1, 1'b1, 1'b0, D_TW};
         5'd13: u = '{A_PY, B_QY, 1'b0, 1'b1, 1'b0, 1'b0, D_TW};
         5'd14: u = '{A_PZ, B_QZ, 1'b0, 1'b1, 1'b0, 1'b1, D_TW};
         5'd15: u = '{A_TX, B_QW, 1'b0, 1'b0, 1'b1, 1'b0, D_RX};
         5'd16: u = '{A_TY, B_QZ, 1'b0, 1'b1, 1'b0, 1'b0, D_RX};
         5'd17: u = '{A_TZ, B_QY, 1'b0, 1'b0, 1'b0, 1'b0, D_RX};
         5'd18: u = '{A_TW, B_QX, 1'b0, 1'b1, 1'b0, 1'b1, D_RX};
         5'd19: u = '{A_TX, B_QZ, 1'b0, 1'b0, 1'b1, 1'b0, D_RY};
         5'd20: u = '{A_TY, B_QW, 1'b0, 1'b0, 1'b0, 1'b0, D_RY};
         5'd21: u = '{A_TZ, B_QX, 1'b0, 1'b1, 1'b0, 1'b0, D_RY};
         5'd22: u = '{A_TW, B_QY, 1'b0, 1'b1, 1'b0, 1'b1, D_RY};
         5'd23: u = '{A_TX, B_QY, 1'b0, 1'b1, 1'b1, 1'b0, D_RZ};
         5'd24: u = '{A_TY, B_QX, 1'b0, 1'b0, 1'b0, 1'b0, D_RZ};
         5'd25: u = '{A_TZ, B_QW, 1'b0, 1'b0, 1'b0, 1'b0, D_RZ};
         5'd26: u = '{A_TW, B_QZ, 1'b0, 1'b1, 1'b0, 1'b1, D_RZ};
         default: u = '{A_AX, B_CY, 1'b0, 1'b0, 1'b0, 1'b0, D_QX};
      endcase
      return u;
   endfunction

   function automatic logic [29:0] atan_val(input logic [IDX_W-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/quaternion_point_rotator_core.sv
// load: the point is written at accept, then the finish state loads the result register
// rotate: iterative cordic steps, then the 27 micro-ops through the single shared multiplier,
// then a drain state and the finish state; no new transaction is taken until back in idle
// a finished result waits in the output register while the next transaction is taken
// reset: synchronous active high, point cleared to zero, no result pending
`default_nettype none
module quaternion_point_rotator_core
   import qpr_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire qpr_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output qpr_rsp_type      rsp_data
);

   qpr_cmd_type cmd;

   qpr_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   qpr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: rtl/core/qpr_ctrl.sv
// qpr_ctrl: sequencing state machine for load, cordic and multiply phases
// depends on qpr_pkg
`default_nettype none
module qpr_ctrl
   import qpr_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   input  wire logic  req_action,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output qpr_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CORDIC = 5'b00010,
      S_MUL    = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cmd             = '0;
      cmd.cordic_idx  = cnt_ff[IDX_W-1:0];
      cmd.uop_idx     = cnt_ff[IDX_W-1:0];
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               cmd.load_point  = (req_action == ACT_LOAD);
               cmd.cordic_init = (req_action == ACT_ROTATE);
               state_in = (req_action == ACT_ROTATE) ? S_CORDIC : S_FINISH;
            end
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.uop_valid = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_UOPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("accepted transaction did not make block busy");
   a_mul_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (cnt_ff < CNT_W'(NUM_UOPS)))
      else $error("micro-op index out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

FILE: rtl/core/qpr_datapath.sv
// qpr_datapath: point registers, iterative cordic, shared multiplier with
// rounding accumulator, and result register
// depends on qpr_pkg
`default_nettype none
module qpr_datapath
   import qpr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire qpr_req_type req_data,
   input  wire qpr_cmd_type cmd,
   output qpr_rsp_type      rsp_data
);

   localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sh007FFFFFFF;
   localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sh0080000000;

   logic signed [31:0]       px_ff, py_ff, pz_ff;
   logic signed [15:0]       ax_ff, ay_ff, az_ff;
   logic signed [CRD_W-1:0]  x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [OPB_W-1:0]  qx_ff, qy_ff, qz_ff, qw;
   logic signed [OPA_W-1:0]  tx_ff, ty_ff, tz_ff, tw_ff;
   logic signed [OPA_W-1:0]  a_op;
   logic signed [OPB_W-1:0]  b_op;
   logic signed [PROD_W-1:0] prod_ff;
   uop_type                  mu_ff, uop;
   logic                     mv_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_base, acc_sum, term;
   logic signed [PROD_W-1:0] rnd17, rnd28;
   logic signed [CRD_W-1:0]  dx, dy, at, qw_full;
   logic signed [31:0]       clamped;
   logic                     clip, sat_ff;
   qpr_rsp_type              rsp_ff;

   assign rsp_data = rsp_ff;

   // cordic rotation step
   always_comb begin
      dx = y_ff >>> cmd.cordic_idx;
      dy = x_ff >>> cmd.cordic_idx;
      at = CRD_W'(signed'({1'b0, atan_val(cmd.cordic_idx)}));
      if (!z_ff[CRD_W-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   assign qw_full = (x_ff + CRD_W'(2)) >>> 2;
   assign qw      = qw_full[OPB_W-1:0];
   assign uop     = uop_rom(cmd.uop_idx);

   always_comb begin
      case (uop.a_sel)
         A_AX:    a_op = OPA_W'(ax_ff);
         A_AY:    a_op = OPA_W'(ay_ff);
         A_AZ:    a_op = OPA_W'(az_ff);
         A_PX:    a_op = OPA_W'(px_ff);
         A_PY:    a_op = OPA_W'(py_ff);
         A_PZ:    a_op = OPA_W'(pz_ff);
         A_TX:    a_op = tx_ff;
         A_TY:    a_op = ty_ff;
         A_TZ:    a_op = tz_ff;
         A_TW:    a_op = tw_ff;
         default: a_op = '0;
      endcase
      case (uop.b_sel)
         B_CY:    b_op = y_ff[OPB_W-1:0];
         B_QW:    b_op = qw;
         B_QX:    b_op = qx_ff;
         B_QY:    b_op = qy_ff;
         B_QZ:    b_op = qz_ff;
         default: b_op = '0;
      endcase
   end

   // rounding and accumulate stage
   always_comb begin
      rnd17    = (prod_ff + PROD_W'(65536)) >>> 17;
      rnd28    = (prod_ff + PROD_W'(134217728)) >>> 28;
      term     = mu_ff.sh17 ? ACC_W'(rnd17) : ACC_W'(rnd28);
      acc_base = mu_ff.first ? '0 : acc_ff;
      acc_sum  = mu_ff.neg ? (acc_base - term) : (acc_base + term);
      clip     = 1'b0;
      if (acc_sum > SAT_MAX) begin
         clamped = 32'sh7FFFFFFF;
         clip    = 1'b1;
      end else if (acc_sum < SAT_MIN) begin
         clamped = -32'sh80000000;
         clip    = 1'b1;
      end else begin
         clamped = acc_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         pz_ff <= '0;
         mv_ff <= 1'b0;
      end else begin
         mv_ff <= cmd.uop_valid;
         if (cmd.load_point) begin
            px_ff <= req_data.point_x;
            py_ff <= req_data.point_y;
            pz_ff <= req_data.point_z;
         end else if (mv_ff && mu_ff.last) begin
            case (mu_ff.dest)
               D_RX:    px_ff <= clamped;
               D_RY:    py_ff <= clamped;
               D_RZ:    pz_ff <= clamped;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         ax_ff <= req_data.axis_x;
         ay_ff <= req_data.axis_y;
         az_ff <= req_data.axis_z;
         x_ff  <= GAIN_INV;
         y_ff  <= '0;
         z_ff  <= CRD_W'(req_data.angle) <<< 15;
      end else if (cmd.cordic_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (cmd.cordic_init || cmd.load_point) begin
         sat_ff <= 1'b0;
      end else if (mv_ff && mu_ff.last && clip &&
                   (mu_ff.dest == D_RX || mu_ff.dest == D_RY || mu_ff.dest == D_RZ)) begin
         sat_ff <= 1'b1;
      end
      prod_ff <= a_op * b_op;
      mu_ff   <= uop;
      if (mv_ff) begin
         acc_ff <= acc_sum;
         if (mu_ff.last) begin
            case (mu_ff.dest)
               D_QX:    qx_ff <= acc_sum[OPB_W-1:0];
               D_QY:    qy_ff <= acc_sum[OPB_W-1:0];
               D_QZ:    qz_ff <= acc_sum[OPB_W-1:0];
               D_TX:    tx_ff <= acc_sum[OPA_W-1:0];
               D_TY:    ty_ff <= acc_sum[OPA_W-1:0];
               D_TZ:    tz_ff <= acc_sum[OPA_W-1:0];
               D_TW:    tw_ff <= acc_sum[OPA_W-1:0];
               default: ;
            endcase
         end
      end
      if (cmd.out_load) begin
         rsp_ff.look_x    <= px_ff;
         rsp_ff.look_y    <= py_ff;
         rsp_ff.look_z    <= pz_ff;
         rsp_ff.saturated <= sat_ff;
      end
   end

endmodule
`default_nettype wire
